>>> src/wsfp_pkg.sv
// Package for the websocket frame parser: opcodes, result codes, queue item type.
`default_nettype none
package wsfp_pkg;

    localparam int DATA_W    = 8;
    localparam int OPC_W     = 4;
    localparam int ACT_W     = 3;
    localparam int CODE_W    = 16;
    localparam int LEN_W     = 32;
    localparam int MAXLEN_W  = 16;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 16'd1024;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [OPC_W-1:0] OP_CONT  = 4'd0;
    localparam logic [OPC_W-1:0] OP_TEXT  = 4'd1;
    localparam logic [OPC_W-1:0] OP_BIN   = 4'd2;
    localparam logic [OPC_W-1:0] OP_CLOSE = 4'd8;
    localparam logic [OPC_W-1:0] OP_PING  = 4'd9;
    localparam logic [OPC_W-1:0] OP_PONG  = 4'd10;

    localparam logic [ACT_W-1:0] ACT_DELIVER    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PONG       = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEER_CLOSE = 3'd2;
    localparam logic [ACT_W-1:0] ACT_DISCONNECT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TOO_LONG   = 3'd4;

    localparam logic [CODE_W-1:0] CODE_NONE        = 16'd0;
    localparam logic [CODE_W-1:0] CODE_UNSUPPORTED = 16'd1003;
    localparam logic [CODE_W-1:0] CODE_PROTOCOL    = 16'd1002;

    typedef struct packed {
        logic [OPC_W-1:0]  opcode;
        logic [DATA_W-1:0] data;
        logic              has_data;
        logic              last;
        logic              oversize;
    } qitem_t;

    // payload bytes of these kinds produce results before the last byte
    function automatic logic streams_data(input logic [OPC_W-1:0] op);
        return (op == OP_TEXT) || (op == OP_BIN) || (op == OP_PING);
    endfunction

    function automatic logic ends_session(input logic [OPC_W-1:0] op);
        return !((op == OP_TEXT) || (op == OP_BIN) || (op == OP_PING) || (op == OP_PONG));
    endfunction

endpackage
`default_nettype wire

>>> src/wsfp_front.sv
// Front end: frame header parser, unmasking and result classification.
`default_nettype none
module wsfp_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [wsfp_pkg::MAXLEN_W-1:0]  cfg_wr_data,
    input  wire logic                           accept,
    input  wire logic [wsfp_pkg::DATA_W-1:0]    rx_byte,
    output logic                                push,
    output wsfp_pkg::qitem_t                    push_item
);
    import wsfp_pkg::*;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_MASK,
        PH_DATA
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [OPC_W-1:0]    kind_reg, kind_next;
    logic                masked_reg, masked_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [3:0]          hbl_reg, hbl_next;
    logic                upper_reg, upper_next;
    logic [31:0]         key_reg, key_next;
    logic [1:0]          pos_reg, pos_next;
    logic                ended_reg, ended_next;
    logic [MAXLEN_W-1:0] maxlen_reg;

    logic             lk_go, lk_masked;
    logic [LEN_W-1:0] lk_len;
    logic             sp_go;
    logic [LEN_W-1:0] sp_len;
    logic             fe_go, fe_has;
    logic [DATA_W-1:0] fe_data, kb, d;

    always_comb
    begin
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        hbl_next    = hbl_reg;
        upper_next  = upper_reg;
        key_next    = key_reg;
        pos_next    = pos_reg;
        ended_next  = ended_reg;
        lk_go       = 1'b0;
        lk_masked   = masked_reg;
        lk_len      = len_reg;
        sp_go       = 1'b0;
        sp_len      = len_reg;
        fe_go       = 1'b0;
        fe_has      = 1'b0;
        fe_data     = '0;
        push        = 1'b0;
        push_item.opcode   = kind_reg;
        push_item.data     = '0;
        push_item.has_data = 1'b0;
        push_item.last     = 1'b0;
        push_item.oversize = 1'b0;

        case (pos_reg)
            2'd0:    kb = key_reg[31:24];
            2'd1:    kb = key_reg[23:16];
            2'd2:    kb = key_reg[15:8];
            default: kb = key_reg[7:0];
        endcase
        d = masked_reg ? (rx_byte ^ kb) : rx_byte;

        if (accept && !ended_reg)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    kind_next  = rx_byte[3:0];
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    masked_next = rx_byte[7];
                    upper_next  = 1'b0;
                    len_next    = '0;
                    if (rx_byte[6:0] == LEN7_EXT16)
                    begin
                        hbl_next   = 4'd2;
                        phase_next = PH_EXT;
                    end
                    else if (rx_byte[6:0] == LEN7_EXT64)
                    begin
                        hbl_next   = 4'd8;
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        lk_go     = 1'b1;
                        lk_masked = rx_byte[7];
                        lk_len    = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
                    end
                end
                PH_EXT:
                begin
                    if (hbl_reg > 4'd4)
                    begin
                        if (rx_byte != '0)
                            upper_next = 1'b1;
                    end
                    else
                        len_next = {len_reg[LEN_W-9:0], rx_byte};
                    hbl_next = hbl_reg - 4'd1;
                    if (hbl_next == 4'd0)
                    begin
                        lk_go  = 1'b1;
                        lk_len = upper_next ? {LEN_W{1'b1}} : len_next;
                    end
                end
                PH_MASK:
                begin
                    key_next = {key_reg[23:0], rx_byte};
                    hbl_next = hbl_reg - 4'd1;
                    if (hbl_next == 4'd0)
                        sp_go = 1'b1;
                end
                PH_DATA:
                begin
                    pos_next = pos_reg + 2'd1;
                    len_next = len_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                    if (len_next == '0)
                    begin
                        phase_next = PH_HDR0;
                        fe_go      = 1'b1;
                        fe_has     = 1'b1;
                        fe_data    = d;
                    end
                    else if (streams_data(kind_reg))
                    begin
                        push               = 1'b1;
                        push_item.data     = d;
                        push_item.has_data = 1'b1;
                    end
                end
                default:
                    phase_next = PH_HDR0;
            endcase
        end

        if (lk_go)
        begin
            len_next = lk_len;
            if (lk_len > {{(LEN_W-MAXLEN_W){1'b0}}, maxlen_reg})
            begin
                ended_next         = 1'b1;
                push               = 1'b1;
                push_item.last     = 1'b1;
                push_item.oversize = 1'b1;
            end
            else if (lk_masked)
            begin
                phase_next = PH_MASK;
                hbl_next   = 4'd4;
                key_next   = '0;
            end
            else
            begin
                sp_go  = 1'b1;
                sp_len = lk_len;
            end
        end

        if (sp_go)
        begin
            pos_next = 2'd0;
            if (sp_len == '0)
            begin
                phase_next = PH_HDR0;
                fe_go      = 1'b1;
            end
            else
                phase_next = PH_DATA;
        end

        if (fe_go)
        begin
            if (kind_reg != OP_PONG)
            begin
                push               = 1'b1;
                push_item.last     = 1'b1;
                push_item.has_data = fe_has && !ends_session(kind_reg);
                push_item.data     = fe_data;
            end
            if (ends_session(kind_reg))
                ended_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            kind_reg   <= '0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            hbl_reg    <= '0;
            upper_reg  <= 1'b0;
            key_reg    <= '0;
            pos_reg    <= '0;
            ended_reg  <= 1'b0;
            maxlen_reg <= MAXLEN_RESET;
        end
        else
        begin
            phase_reg  <= phase_next;
            kind_reg   <= kind_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            hbl_reg    <= hbl_next;
            upper_reg  <= upper_next;
            key_reg    <= key_next;
            pos_reg    <= pos_next;
            ended_reg  <= ended_next;
            if (cfg_wr_en)
                maxlen_reg <= cfg_wr_data;
        end
    end

endmodule
`default_nettype wire

>>> src/wsfp_queue.sv
// Short FIFO of classified items between the parser and the output stage.
`default_nettype none
module wsfp_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire wsfp_pkg::qitem_t  push_item,
    input  wire logic              pop,
    output wsfp_pkg::qitem_t       pop_item,
    output logic                   full,
    output logic                   empty
);
    import wsfp_pkg::*;

    qitem_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule
`default_nettype wire

>>> src/wsfp_back.sv
// Back end: maps classified items to actions and close codes, output register.
`default_nettype none
module wsfp_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           q_empty,
    input  wire wsfp_pkg::qitem_t               q_item,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [wsfp_pkg::ACT_W-1:0]          action,
    output logic [wsfp_pkg::OPC_W-1:0]          frame_opcode,
    output logic [wsfp_pkg::DATA_W-1:0]         data_byte,
    output logic                                has_data,
    output logic                                last,
    output logic [wsfp_pkg::CODE_W-1:0]         close_code
);
    import wsfp_pkg::*;

    logic              valid_reg;
    logic [ACT_W-1:0]  act_next;
    logic [CODE_W-1:0] code_next;

    assign q_pop    = !q_empty && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;

    always_comb
    begin
        code_next = CODE_NONE;
        if (q_item.oversize)
            act_next = ACT_TOO_LONG;
        else
        begin
            case (q_item.opcode)
                OP_TEXT, OP_BIN: act_next = ACT_DELIVER;
                OP_PING:         act_next = ACT_PONG;
                OP_CLOSE:        act_next = ACT_PEER_CLOSE;
                OP_CONT:
                begin
                    act_next  = ACT_DISCONNECT;
                    code_next = CODE_UNSUPPORTED;
                end
                default:
                begin
                    act_next  = ACT_DISCONNECT;
                    code_next = CODE_PROTOCOL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            action       <= act_next;
            frame_opcode <= q_item.opcode;
            data_byte    <= q_item.has_data ? q_item.data : '0;
            has_data     <= q_item.has_data;
            last         <= q_item.last;
            close_code   <= code_next;
        end
    end

endmodule
`default_nettype wire

>>> src/websocket_frame_parser.sv
// Top level of the websocket receive frame parser.
// Throughput: one received byte per cycle; s_tready drops only when the 4-entry
// result queue is full. The queue is written at the accepting edge; an item moves on to
// the output register, raising m_tvalid, once that register is empty or being taken.
// Reset (rst_n, asynchronous): parser to first header byte, queue and output
// emptied, max_payload_len back to 1024; an ended session clears only on reset.
`default_nettype none
module websocket_frame_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,   // max_payload_len
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,       // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,       // [3:0] frame_opcode, [11:4] data_byte,
                                            // [27:12] close_code, [31:28] zero
    output logic [3:0]       m_tuser,       // [2:0] action, [3] has_data
    output logic             m_tlast        // last
);
    import wsfp_pkg::*;

    qitem_t            push_item, pop_item;
    logic              push, pop, q_full, q_empty;
    logic              accept;
    logic [ACT_W-1:0]  action;
    logic [OPC_W-1:0]  frame_opcode;
    logic [DATA_W-1:0] data_byte;
    logic              has_data;
    logic [CODE_W-1:0] close_code;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    wsfp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .rx_byte     (s_tdata),
        .push        (push),
        .push_item   (push_item)
    );

    wsfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    wsfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (pop_item),
        .q_pop        (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .action       (action),
        .frame_opcode (frame_opcode),
        .data_byte    (data_byte),
        .has_data     (has_data),
        .last         (m_tlast),
        .close_code   (close_code)
    );

    assign m_tdata = {4'b0000, close_code, data_byte, frame_opcode};
    assign m_tuser = {has_data, action};

endmodule
`default_nettype wire

>>> dv/websocket_frame_parser_test.sv
// Self-checking testbench for the websocket frame parser: random frames, stalls, config phases.
`timescale 1ns / 1ps
module websocket_frame_parser_test;
    import wsfp_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_BYTES = 700;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;

    typedef enum logic [2:0] {
        PARSE_HDR0,
        PARSE_HDR1,
        PARSE_EXT,
        PARSE_MASK,
        PARSE_DATA
    } parse_phase_t;

    typedef enum int {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } len_form_t;

    typedef enum int {
        END_CLOSE,
        END_CONT,
        END_UNKNOWN,
        END_LONG_SHORT,
        END_LONG_EXT16,
        END_LONG_EXT64
    } end_kind_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [OPC_W-1:0]  opcode;
        logic [DATA_W-1:0] data;
        logic              has_data;
        logic              last;
        logic [CODE_W-1:0] code;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'h0000;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;       // [3:0] frame_opcode, [11:4] data_byte, [27:12] close_code
    logic [3:0]  m_tuser;       // [2:0] action, [3] has_data
    logic        m_tlast;

    // parser state mirror
    parse_phase_t        rx_phase;
    logic [OPC_W-1:0]    cur_kind;
    logic                cur_masked;
    logic [LEN_W-1:0]    bytes_left;
    logic [3:0]          hdr_left;
    logic                upper_nonzero;
    logic [31:0]         cur_key;
    logic [1:0]          key_idx;
    logic                session_over;
    logic [MAXLEN_W-1:0] max_len;

    frame_result_t parser_results_due[$];

    int mismatch_count = 0;
    int cycle_count = 0;
    int bytes_sent = 0;
    int src_burst = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int sink_wait = 0;
    int sink_burst = 0;
    int unsigned sink_pick;

    websocket_frame_parser DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls, bursts, and a long hold on request
    always @(posedge clk)
    begin
        if (hold_ack != hold_req)
        begin
            hold_ack <= hold_req;
            sink_wait <= LONG_HOLD;
            sink_burst <= 0;
            m_tready <= 1'b0;
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
            m_tready <= 1'b0;
        end
        else if (sink_burst != 0)
        begin
            sink_burst <= sink_burst - 1;
            m_tready <= 1'b1;
        end
        else
        begin
            sink_pick = $urandom_range(0, 99);
            if (sink_pick < 4)
            begin
                sink_burst <= $urandom_range(30, 150);
                m_tready <= 1'b1;
            end
            else if (sink_pick < 20)
            begin
                sink_wait <= $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else if (sink_pick < 23)
            begin
                sink_wait <= $urandom_range(10, 40);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (parser_results_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: tdata %h tuser %h tlast %b",
                             m_tdata, m_tuser, m_tlast);
            end
            else
            begin
                want = parser_results_due.pop_front();
                if (m_tdata !== {4'h0, want.code, want.data, want.opcode} ||
                    m_tuser !== {want.has_data, want.action} ||
                    m_tlast !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: exp act %0d op %0d data %h has %b last %b code %0d",
                                 want.action, want.opcode, want.data, want.has_data,
                                 want.last, want.code);
                        $display("          got act %0d op %0d data %h has %b last %b code %0d",
                                 m_tuser[2:0], m_tdata[3:0], m_tdata[11:4], m_tuser[3],
                                 m_tlast, m_tdata[27:12]);
                    end
                end
            end
        end
    end

    task automatic reset_parser_state();
        rx_phase = PARSE_HDR0;
        cur_kind = '0;
        cur_masked = 1'b0;
        bytes_left = '0;
        hdr_left = '0;
        upper_nonzero = 1'b0;
        cur_key = '0;
        key_idx = '0;
        session_over = 1'b0;
        max_len = MAXLEN_RESET;
    endtask

    task automatic note_result(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] data,
                               input logic has, input logic last, input logic [CODE_W-1:0] code);
        frame_result_t r;
        r.action = act;
        r.opcode = cur_kind;
        r.data = has ? data : '0;
        r.has_data = has;
        r.last = last;
        r.code = code;
        parser_results_due.push_back(r);
    endtask

    task automatic finish_frame(input logic [DATA_W-1:0] data, input logic has);
        case (cur_kind)
            OP_TEXT, OP_BIN: note_result(ACT_DELIVER, data, has, 1'b1, CODE_NONE);
            OP_PING:         note_result(ACT_PONG, data, has, 1'b1, CODE_NONE);
            OP_PONG:         ;
            OP_CLOSE:
            begin
                session_over = 1'b1;
                note_result(ACT_PEER_CLOSE, '0, 1'b0, 1'b1, CODE_NONE);
            end
            OP_CONT:
            begin
                session_over = 1'b1;
                note_result(ACT_DISCONNECT, '0, 1'b0, 1'b1, CODE_UNSUPPORTED);
            end
            default:
            begin
                session_over = 1'b1;
                note_result(ACT_DISCONNECT, '0, 1'b0, 1'b1, CODE_PROTOCOL);
            end
        endcase
    endtask

    task automatic open_payload();
        key_idx = '0;
        if (bytes_left == 0)
        begin
            rx_phase = PARSE_HDR0;
            finish_frame('0, 1'b0);
        end
        else
            rx_phase = PARSE_DATA;
    endtask

    task automatic check_length();
        if (bytes_left > {16'h0000, max_len})
        begin
            session_over = 1'b1;
            note_result(ACT_TOO_LONG, '0, 1'b0, 1'b1, CODE_NONE);
        end
        else if (cur_masked)
        begin
            rx_phase = PARSE_MASK;
            hdr_left = 4'd4;
            cur_key = '0;
        end
        else
            open_payload();
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        logic [7:0] kb;
        logic [7:0] d;
        if (!session_over)
        begin
            case (rx_phase)
                PARSE_HDR0:
                begin
                    cur_kind = b[3:0];
                    rx_phase = PARSE_HDR1;
                end
                PARSE_HDR1:
                begin
                    cur_masked = b[7];
                    upper_nonzero = 1'b0;
                    bytes_left = '0;
                    if (b[6:0] == LEN7_EXT16)
                    begin
                        hdr_left = 4'd2;
                        rx_phase = PARSE_EXT;
                    end
                    else if (b[6:0] == LEN7_EXT64)
                    begin
                        hdr_left = 4'd8;
                        rx_phase = PARSE_EXT;
                    end
                    else
                    begin
                        bytes_left = {25'h0, b[6:0]};
                        check_length();
                    end
                end
                PARSE_EXT:
                begin
                    if (hdr_left > 4'd4)
                    begin
                        if (b != 8'h00)
                            upper_nonzero = 1'b1;
                    end
                    else
                        bytes_left = {bytes_left[23:0], b};
                    hdr_left = hdr_left - 4'd1;
                    if (hdr_left == 0)
                    begin
                        if (upper_nonzero)
                            bytes_left = '1;
                        check_length();
                    end
                end
                PARSE_MASK:
                begin
                    cur_key = {cur_key[23:0], b};
                    hdr_left = hdr_left - 4'd1;
                    if (hdr_left == 0)
                        open_payload();
                end
                PARSE_DATA:
                begin
                    kb = cur_key[(3 - int'(key_idx)) * 8 +: 8];
                    d = cur_masked ? (b ^ kb) : b;
                    key_idx = key_idx + 2'd1;
                    bytes_left = bytes_left - 1;
                    if (bytes_left == 0)
                    begin
                        rx_phase = PARSE_HDR0;
                        finish_frame(d, 1'b1);
                    end
                    else if (cur_kind == OP_TEXT || cur_kind == OP_BIN)
                        note_result(ACT_DELIVER, d, 1'b1, 1'b0, CODE_NONE);
                    else if (cur_kind == OP_PING)
                        note_result(ACT_PONG, d, 1'b1, 1'b0, CODE_NONE);
                end
                default:
                    rx_phase = PARSE_HDR0;
            endcase
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        int unsigned pick;
        gap = 0;
        if (src_burst > 0)
            src_burst--;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                src_burst = $urandom_range(20, 80);
            else if (pick < 60)
                gap = 0;
            else if (pick < 85)
                gap = $urandom_range(1, 2);
            else if (pick < 96)
                gap = $urandom_range(3, 6);
            else
                gap = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        parse_rx_byte(b);
        bytes_sent++;
    endtask

    // all results in, then let header-only or pong bytes settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (parser_results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_max_len(input logic [15:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        max_len = value;
    endtask

    function automatic logic [7:0] payload_byte();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 8'h00;
        if (pick == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic len_form_t pick_form(input int unsigned len);
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (len <= 125 && pick < 6)
            return LEN_SHORT;
        if (pick < 8)
            return LEN_EXT16;
        return LEN_EXT64;
    endfunction

    task automatic send_frame(input logic [OPC_W-1:0] op, input logic [63:0] len,
                              input logic masked, input len_form_t form);
        logic [31:0] key;
        logic [6:0]  len7;
        int unsigned n;
        key = $urandom;
        send_byte({4'($urandom_range(0, 15)), op});
        case (form)
            LEN_SHORT: len7 = len[6:0];
            LEN_EXT16: len7 = LEN7_EXT16;
            default:   len7 = LEN7_EXT64;
        endcase
        send_byte({masked, len7});
        if (form == LEN_EXT16)
        begin
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        else if (form == LEN_EXT64)
        begin
            for (int i = 7; i >= 0; i--)
                send_byte(len[8*i +: 8]);
        end
        if (!session_over && masked)
        begin
            for (int i = 3; i >= 0; i--)
                send_byte(key[8*i +: 8]);
        end
        if (!session_over)
        begin
            for (n = 0; n < len[31:0]; n++)
                send_byte(payload_byte());
        end
    endtask

    task automatic test_basic_frames();
        send_frame(OP_TEXT, 64'd0, 1'b0, LEN_SHORT);
        send_frame(OP_BIN, 64'd0, 1'b1, LEN_SHORT);
        send_frame(OP_PING, 64'd0, 1'b0, LEN_EXT16);
        send_frame(OP_PONG, 64'd0, 1'b1, LEN_EXT64);
        send_frame(OP_TEXT, 64'd1, 1'b0, LEN_SHORT);
        send_frame(OP_BIN, 64'd9, 1'b1, LEN_SHORT);
        send_frame(OP_PING, 64'd5, 1'b1, LEN_SHORT);
        send_frame(OP_PONG, 64'd4, 1'b0, LEN_SHORT);
        send_frame(OP_TEXT, 64'd125, 1'b1, LEN_SHORT);
        send_frame(OP_BIN, 64'd130, 1'b0, LEN_EXT16);
        send_frame(OP_PING, 64'd3, 1'b0, LEN_EXT64);
    endtask

    task automatic test_zero_limit();
        set_max_len(16'd0);
        send_frame(OP_TEXT, 64'd0, 1'b1, LEN_EXT16);
        send_frame(OP_BIN, 64'd0, 1'b0, LEN_EXT64);
        send_frame(OP_PING, 64'd0, 1'b1, LEN_SHORT);
        send_frame(OP_PONG, 64'd0, 1'b0, LEN_SHORT);
    endtask

    task automatic test_length_boundary();
        set_max_len(16'd6);
        send_frame(OP_TEXT, 64'd6, 1'b1, LEN_EXT16);
        send_frame(OP_PING, 64'd6, 1'b1, LEN_EXT64);
        send_frame(OP_BIN, 64'd6, 1'b0, LEN_SHORT);
        send_frame(OP_PONG, 64'd6, 1'b1, LEN_SHORT);
        set_max_len(16'hFFFF);
        send_frame(OP_BIN, 64'd200, 1'b1, LEN_EXT64);
    endtask

    task automatic test_full_queue();
        set_max_len(MAXLEN_RESET);
        hold_req <= hold_req + 1;
        src_burst = 200;
        send_frame(OP_TEXT, 64'd80, 1'b1, LEN_SHORT);
    endtask

    task automatic test_random_traffic();
        int unsigned limit;
        int unsigned cap;
        int unsigned len;
        int unsigned pick;
        int stop_at;
        int seg;
        logic [OPC_W-1:0] op;
        stop_at = bytes_sent + RANDOM_BYTES;
        seg = 0;
        while (bytes_sent < stop_at)
        begin
            case (seg % 4)
                0:       limit = 65535;
                1:       limit = MAXLEN_RESET;
                2:       limit = $urandom_range(1, 300);
                default: limit = $urandom_range(0, 3);
            endcase
            set_max_len(16'(limit));
            repeat (25)
            begin
                if (bytes_sent < stop_at)
                begin
                    case ($urandom_range(0, 3))
                        0:       op = OP_TEXT;
                        1:       op = OP_BIN;
                        2:       op = OP_PING;
                        default: op = OP_PONG;
                    endcase
                    pick = $urandom_range(0, 99);
                    cap = (pick < 70) ? 20 : (pick < 92) ? 125 : 400;
                    if (cap > limit)
                        cap = limit;
                    len = $urandom_range(0, cap);
                    send_frame(op, 64'(len), 1'($urandom_range(0, 1)), pick_form(len));
                end
            end
            seg++;
        end
    endtask

    // only one ending case fits in a run, the seed picks which
    task automatic test_session_end();
        end_kind_t kind;
        int unsigned limit;
        int unsigned len;
        logic [31:0] upper;
        logic [OPC_W-1:0] op;
        kind = end_kind_t'($urandom_range(0, 5));
        case (kind)
            END_CLOSE, END_CONT, END_UNKNOWN:
            begin
                if (kind == END_CLOSE)
                    op = OP_CLOSE;
                else if (kind == END_CONT)
                    op = OP_CONT;
                else
                begin
                    op = OP_CONT;
                    while (op == OP_CONT || op == OP_TEXT || op == OP_BIN ||
                           op == OP_CLOSE || op == OP_PING || op == OP_PONG)
                        op = 4'($urandom_range(0, 15));
                end
                len = $urandom_range(0, 8);
                send_frame(op, 64'(len), 1'($urandom_range(0, 1)), pick_form(len));
            end
            END_LONG_SHORT:
            begin
                limit = $urandom_range(0, 124);
                set_max_len(16'(limit));
                len = $urandom_range(limit + 1, 125);
                send_frame(OP_TEXT, 64'(len), 1'($urandom_range(0, 1)), LEN_SHORT);
            end
            END_LONG_EXT16:
            begin
                limit = $urandom_range(0, 65534);
                set_max_len(16'(limit));
                len = $urandom_range(limit + 1, 65535);
                send_frame(OP_PING, 64'(len), 1'($urandom_range(0, 1)), LEN_EXT16);
            end
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    set_max_len(16'hFFFF);
                    len = 65536 + $urandom_range(0, 1000);
                    send_frame(OP_BIN, {32'h0, 32'(len)}, 1'b1, LEN_EXT64);
                end
                else
                begin
                    upper = $urandom;
                    if (upper == 0)
                        upper = 32'h1;
                    send_frame(OP_BIN, {upper, 32'($urandom)}, 1'($urandom_range(0, 1)),
                               LEN_EXT64);
                end
            end
        endcase
        repeat (16) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        reset_parser_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_frames();
        test_zero_limit();
        test_length_boundary();
        test_full_queue();
        test_random_traffic();
        test_session_end();
        wait_idle();
        if (mismatch_count == 0 && parser_results_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
